/* design/assert_macros.svh */
// Assertion macros used by the checker file sbmq_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SBMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbmq assertion failed");

// next-cycle implication
`define SBMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbmq assertion failed");

`endif

/* design/sbmq_pkg.sv */
// Shared types and constants of the shared buffer multi queue.
// No dependencies.
`default_nettype none

package sbmq_pkg;

	localparam int NUM_SLOTS  = 16;
	localparam int NUM_QUEUES = 4;
	localparam int DATA_WIDTH = 32;

	localparam int QID_W  = 2;
	localparam int WORD_W = 32;
	localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
	localparam int SLOT_W = $clog2(NUM_SLOTS);

	localparam logic [PTR_W-1:0]  NIL_PTR   = PTR_W'(NUM_SLOTS);
	localparam logic [WORD_W-1:0] WORD_ONES = '1;

	typedef enum logic {
		MODE_ENQ = 1'b0,
		MODE_DEQ = 1'b1
	} op_mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [WORD_W-1:0] data_in;
		logic [QID_W-1:0]  queue_id;
		op_mode_t          mode;
	} sbmq_op_t;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] data_out;
	} sbmq_res_t;

endpackage

`default_nettype wire

/* design/sbmq_list.sv */
// Linked-list state of the shared buffer: free list, per-queue head and tail, slot storage.
// Depends on sbmq_pkg.
`default_nettype none

module sbmq_list (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              op_en,
	input  wire sbmq_pkg::sbmq_op_t op,
	output sbmq_pkg::sbmq_res_t     res
);
	import sbmq_pkg::*;

	logic [PTR_W-1:0]      free_head_q;
	logic [PTR_W-1:0]      head_ptr_q [NUM_QUEUES];
	logic [PTR_W-1:0]      tail_ptr_q [NUM_QUEUES];
	logic [PTR_W-1:0]      link_ptr_q [NUM_SLOTS];
	logic [DATA_WIDTH-1:0] payload_q  [NUM_SLOTS];

	logic                  qid_ok;
	logic                  free_ok;
	logic                  hd_ok;
	logic                  tl_ok;
	logic [PTR_W-1:0]      hd;
	logic [PTR_W-1:0]      tl;
	logic [PTR_W-1:0]      slot;
	logic [PTR_W-1:0]      link_rd;
	logic [DATA_WIDTH-1:0] word_rd;
	logic                  enq_go;
	logic                  deq_go;

	always_comb begin
		qid_ok  = int'(op.queue_id) < NUM_QUEUES;
		hd      = qid_ok ? head_ptr_q[op.queue_id] : NIL_PTR;
		tl      = qid_ok ? tail_ptr_q[op.queue_id] : NIL_PTR;
		free_ok = free_head_q < NIL_PTR;
		hd_ok   = hd < NIL_PTR;
		tl_ok   = tl < NIL_PTR;
		enq_go  = (op.mode == MODE_ENQ) && qid_ok && free_ok;
		deq_go  = (op.mode == MODE_DEQ) && qid_ok && hd_ok;
		slot    = (op.mode == MODE_ENQ) ? free_head_q : hd;
		link_rd = link_ptr_q[slot[SLOT_W-1:0]];
		word_rd = payload_q[slot[SLOT_W-1:0]];
	end

	always_comb begin
		unique case (op.mode)
			MODE_ENQ: begin
				res.data_out = '0;
				res.status   = enq_go ? ST_OK : ST_OVERFLOW;
			end
			MODE_DEQ: begin
				res.data_out = deq_go ? WORD_W'(word_rd) : WORD_ONES;
				res.status   = deq_go ? ST_OK : ST_UNDERFLOW;
			end
			default: begin
				res.data_out = '0;
				res.status   = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_ptr_q[i] <= NIL_PTR;
				tail_ptr_q[i] <= NIL_PTR;
			end
			for (int i = 0; i < NUM_SLOTS; i++) begin
				link_ptr_q[i] <= PTR_W'(i + 1);
			end
		end else if (op_en && enq_go) begin
			free_head_q <= link_rd;
			if (!hd_ok) begin
				head_ptr_q[op.queue_id] <= slot;
			end else if (tl_ok) begin
				link_ptr_q[tl[SLOT_W-1:0]] <= slot;
			end
			link_ptr_q[slot[SLOT_W-1:0]] <= NIL_PTR;
			tail_ptr_q[op.queue_id]      <= slot;
		end else if (op_en && deq_go) begin
			head_ptr_q[op.queue_id]      <= link_rd;
			link_ptr_q[slot[SLOT_W-1:0]] <= free_head_q;
			free_head_q                  <= slot;
		end
	end

	always_ff @(posedge clk) begin
		if (op_en && enq_go) begin
			payload_q[slot[SLOT_W-1:0]] <= op.data_in[DATA_WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

/* design/shared_buffer_multi_queue.sv */
// Shared buffer multi queue: several FIFO queues as linked lists in one slot buffer.
// Depends on sbmq_pkg and sbmq_list.
//
// Input channel s_*: one item is an enqueue (mode 0, word in s_tdata) or a
// dequeue (mode 1) addressed to queue queue_id. Output channel m_*: exactly
// one item per request: the dequeued word, or 0 for an enqueue, with a status
// of ok, overflow (no free slot) or underflow (empty queue, word all ones).
// An accepted item is loaded into the input register (op_s1); when the output
// may advance, the list update is done and the result register (res_q) is
// loaded, which drives m_tvalid. One item is taken every cycle while the
// result register is empty or m_tready is high; the bound is the combinational
// read of the free head or queue head link and the write back of the pointers,
// which the next item reads.
// Reset empties all queues and chains every slot into the free list; stored
// words are not cleared, no warm-up pass is needed.
// When m_tready is low the result holds; one more item may sit in the input
// register, then s_tready drops until the result is taken.
`default_nettype none

module shared_buffer_multi_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // data_in[31:0]
	input  wire logic [2:0]  s_tuser,  // mode[0], queue_id[2:1]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // data_out[31:0]
	output logic [1:0]       m_tuser   // status[1:0]
);
	import sbmq_pkg::*;

	sbmq_op_t  op_s1;
	logic      op_valid_s1;
	sbmq_res_t res_q;
	logic      res_valid_q;
	sbmq_res_t res;
	logic      advance;

	assign advance  = !res_valid_q || m_tready;
	assign s_tready = !op_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				op_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				res_valid_q <= op_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1.data_in  <= s_tdata;
			op_s1.queue_id <= s_tuser[2:1];
			op_s1.mode     <= op_mode_t'(s_tuser[0]);
		end
		if (advance && op_valid_s1) begin
			res_q <= res;
		end
	end

	sbmq_list u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.op_en  (op_valid_s1 && advance),
		.op     (op_s1),
		.res    (res)
	);

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_q.data_out;
	assign m_tuser  = res_q.status;

endmodule

`default_nettype wire

/* design/sbmq_checker.sv */
// Port-level checks of shared_buffer_multi_queue, bound to the top level.
// Depends on sbmq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sbmq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic [2:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import sbmq_pkg::*;

	logic in_stall;
	logic out_stall;
	logic out_underflow;
	logic out_overflow;

	assign in_stall      = s_tvalid && !s_tready;
	assign out_stall     = m_tvalid && !m_tready;
	assign out_underflow = m_tvalid && (m_tuser == ST_UNDERFLOW);
	assign out_overflow  = m_tvalid && (m_tuser == ST_OVERFLOW);

	`SBMQ_ASSERT_NEXT(a_in_hold, clk, arst_n, in_stall, s_tvalid && $stable(s_tdata) && $stable(s_tuser))
	`SBMQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`SBMQ_ASSERT_NOW(a_underflow_ones, clk, arst_n, out_underflow, m_tdata == WORD_ONES)
	`SBMQ_ASSERT_NOW(a_overflow_zero, clk, arst_n, out_overflow, m_tdata == '0)
	`SBMQ_ASSERT_NOW(a_ready_when_drained, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* verif/shared_buffer_multi_queue_tb.sv */
// Self-checking testbench of shared_buffer_multi_queue: directed table, then random traffic.
// Checks the m_* items in order against the table's fixed results or its own linked-list buffer model.
// Depends on sbmq_pkg and the RTL of the block.
`default_nettype none

module shared_buffer_multi_queue_tb;
	import sbmq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		op_mode_t    mode;
		logic [1:0]  qid;
		logic [31:0] word;
		bit          fixed;
		status_t     st;
		logic [31:0] dout;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	logic [PTR_W-1:0]  buf_free;
	logic [PTR_W-1:0]  buf_head [NUM_QUEUES];
	logic [PTR_W-1:0]  buf_tail [NUM_QUEUES];
	logic [PTR_W-1:0]  buf_link [NUM_SLOTS];
	logic [WORD_W-1:0] buf_word [NUM_SLOTS];

	sbmq_res_t due_results[$];
	dir_row_t  dir_rows[$];
	int        errors = 0;
	int        hold_req = 0;
	bit        steady = 1'b0;

	shared_buffer_multi_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_buffer_model();
		buf_free = '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			buf_head[i] = NIL_PTR;
			buf_tail[i] = NIL_PTR;
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			buf_link[i] = PTR_W'(i + 1);
			buf_word[i] = '0;
		end
		buf_link[NUM_SLOTS-1] = NIL_PTR;
	endfunction

	function automatic sbmq_res_t apply_queue_op(input sbmq_op_t op);
		sbmq_res_t        r;
		logic [PTR_W-1:0] slot;
		r.status   = ST_OK;
		r.data_out = '0;
		if (op.mode == MODE_ENQ) begin
			if (op.queue_id >= NUM_QUEUES || buf_free >= NUM_SLOTS) begin
				r.status = ST_OVERFLOW;
			end else begin
				slot = buf_free;
				buf_free = buf_link[slot];
				if (buf_head[op.queue_id] >= NUM_SLOTS) begin
					buf_head[op.queue_id] = slot;
				end else if (buf_tail[op.queue_id] < NUM_SLOTS) begin
					buf_link[buf_tail[op.queue_id]] = slot;
				end
				buf_link[slot] = NIL_PTR;
				buf_tail[op.queue_id] = slot;
				buf_word[slot] = op.data_in;
			end
		end else begin
			if (op.queue_id >= NUM_QUEUES || buf_head[op.queue_id] >= NUM_SLOTS) begin
				r.status   = ST_UNDERFLOW;
				r.data_out = WORD_ONES;
			end else begin
				slot = buf_head[op.queue_id];
				buf_head[op.queue_id] = buf_link[slot];
				buf_link[slot] = buf_free;
				buf_free = slot;
				r.data_out = buf_word[slot];
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_row(input op_mode_t m, input logic [1:0] q, input logic [31:0] w,
			input bit fixed, input status_t st, input logic [31:0] d);
		dir_row_t row;
		row.mode  = m;
		row.qid   = q;
		row.word  = w;
		row.fixed = fixed;
		row.st    = st;
		row.dout  = d;
		dir_rows.push_back(row);
	endfunction

	task automatic offer(input sbmq_op_t op, input bit fixed, input sbmq_res_t fixed_res);
		sbmq_res_t pred;
		while (!steady && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= op.data_in;
		s_tuser  <= {op.queue_id, op.mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = apply_queue_op(op);
		due_results.push_back(fixed ? fixed_res : pred);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		static int hold_seen = 0;
		static int hold_left = 0;
		sbmq_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t unexpected item: expected none, actual data %h status %0d",
						$time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (m_tdata !== want.data_out) begin
						$display("%0t data_out mismatch: expected %h, actual %h",
							$time, want.data_out, m_tdata);
						errors++;
					end
					if (m_tuser !== want.status) begin
						$display("%0t status mismatch: expected %0d, actual %0d",
							$time, want.status, m_tuser);
						errors++;
					end
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 11);
			end
		end
	end

	initial begin
		sbmq_op_t  op;
		sbmq_res_t fixed_res;
		int        enq_pct;
		int        wait_cnt;

		clear_buffer_model();

		// empty queues after reset
		for (int q = 0; q < NUM_QUEUES; q++)
			add_row(MODE_DEQ, 2'(q), $urandom, 1'b1, ST_UNDERFLOW, WORD_ONES);
		add_row(MODE_ENQ, 2'd0, 32'h8000_0000, 1'b1, ST_OK, '0);
		add_row(MODE_ENQ, 2'd1, 32'h7fff_ffff, 1'b1, ST_OK, '0);
		add_row(MODE_ENQ, 2'd2, 32'h0000_0000, 1'b1, ST_OK, '0);
		add_row(MODE_ENQ, 2'd3, 32'hffff_ffff, 1'b1, ST_OK, '0);
		add_row(MODE_DEQ, 2'd0, 32'h0, 1'b1, ST_OK, 32'h8000_0000);
		// queue emptied, stale tail left behind
		add_row(MODE_DEQ, 2'd0, 32'hffff_ffff, 1'b1, ST_UNDERFLOW, WORD_ONES);
		add_row(MODE_ENQ, 2'd0, 32'h5a5a_a5a5, 1'b0, ST_OK, '0);
		// fill every remaining slot, then overflow
		for (int i = 0; i < NUM_SLOTS - 4; i++)
			add_row(MODE_ENQ, 2'(i % NUM_QUEUES), $urandom, 1'b1, ST_OK, '0);
		add_row(MODE_ENQ, 2'd1, 32'h1234_5678, 1'b1, ST_OVERFLOW, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			op.mode     = dir_rows[i].mode;
			op.queue_id = dir_rows[i].qid;
			op.data_in  = dir_rows[i].word;
			fixed_res.status   = dir_rows[i].st;
			fixed_res.data_out = dir_rows[i].dout;
			offer(op, dir_rows[i].fixed, fixed_res);
		end

		enq_pct = 50;
		for (int n = 0; n < 1600; n++) begin
			if (n % 80 == 0) begin
				case ($urandom_range(4))
					0: enq_pct = 5;
					1: enq_pct = 25;
					2: enq_pct = 50;
					3: enq_pct = 75;
					default: enq_pct = 95;
				endcase
			end
			if (n == 400) begin
				hold_req <= hold_req + 1;
				steady   <= 1'b1;
			end
			if (n == 440)
				steady <= 1'b0;
			if (n == 800) begin
				while (due_results.size() != 0) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
				end
			end
			if (n == 1000)
				steady <= 1'b1;
			if (n == 1300)
				steady <= 1'b0;
			op.mode     = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
			op.queue_id = 2'($urandom_range(NUM_QUEUES - 1));
			op.data_in  = rand_word();
			offer(op, 1'b0, fixed_res);
		end

		s_tvalid <= 1'b0;
		wait_cnt = 0;
		while (due_results.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (20) @(posedge clk);
		if (due_results.size() != 0) begin
			$display("%0t missing items: expected %0d more, actual 0",
				$time, due_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("shared_buffer_multi_queue_tb: PASS");
		end else begin
			$display("shared_buffer_multi_queue_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("shared_buffer_multi_queue_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
